// ===== rtl/ccb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_pkg
// Shared types and constants of the clipped colour-key blitter.
// ----------------------------------------------------------------------------
package ccb_pkg;

    localparam int DIM_W = 11;   // coordinate and size width
    localparam int IDX_W = 20;   // linear index width
    localparam int PIX_W = 8;    // pixel width
    localparam int SW_W  = 14;   // signed working width of the clip arithmetic

    localparam logic [DIM_W-1:0] SCREEN_WIDTH_RST  = 11'd132;
    localparam logic [DIM_W-1:0] SCREEN_HEIGHT_RST = 11'd176;

    // register indexes of the configuration port
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // request type codes
    localparam logic REQ_SETUP = 1'b0;
    localparam logic REQ_PIXEL = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [DIM_W-1:0] dest_x;
        logic [DIM_W-1:0] dest_y;
        logic [DIM_W-1:0] req_width;
        logic [DIM_W-1:0] req_height;
        logic [DIM_W-1:0] src_x;
        logic [DIM_W-1:0] src_y;
        logic [DIM_W-1:0] bmp_width;
        logic [DIM_W-1:0] bmp_height;
        logic [PIX_W-1:0] key_color;
        logic             key_flag;
        logic [PIX_W-1:0] pixel;
    } item_t;

    typedef struct packed {
        logic             ok;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [IDX_W-1:0] src_start;
        logic [IDX_W-1:0] row_base;
    } clip_t;

    typedef struct packed {
        logic [IDX_W-1:0] dest_index;
        logic             write_enable;
        logic [PIX_W-1:0] pixel_out;
        logic             last;
    } pix_res_t;

    typedef struct packed {
        logic             accepted;
        logic [DIM_W-1:0] clip_width;
        logic [DIM_W-1:0] clip_height;
        logic [IDX_W-1:0] src_start;
        pix_res_t         pix;
    } result_t;

endpackage

// ===== rtl/ccb_clip.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_clip
// Clips a requested blit window to the screen and to the bitmap.
// ----------------------------------------------------------------------------
module ccb_clip
(
    input  ccb_pkg::item_t            item,
    input  logic [ccb_pkg::DIM_W-1:0] screen_width,
    input  logic [ccb_pkg::DIM_W-1:0] screen_height,
    output ccb_pkg::clip_t            clip
);

    logic signed [ccb_pkg::SW_W-1:0] sw_s, sh_s, bw_s, bh_s;
    logic signed [ccb_pkg::SW_W-1:0] x_a, y_a, x0_a, y0_a, sx_a, sy_a;
    logic signed [ccb_pkg::SW_W-1:0] x_b, y_b, x0_b, y0_b, sx_b, sy_b;
    logic signed [ccb_pkg::SW_W-1:0] sx_c, sy_c, sx_d, sy_d;
    logic                            reject_a, reject_b, ok;
    logic [2*ccb_pkg::DIM_W-1:0]     row_prod, src_prod;

    always_comb
    begin
        sw_s = {3'b000, screen_width};
        sh_s = {3'b000, screen_height};
        bw_s = {3'b000, item.bmp_width};
        bh_s = {3'b000, item.bmp_height};
        x_a  = {{3{item.dest_x[ccb_pkg::DIM_W-1]}}, item.dest_x};
        y_a  = {{3{item.dest_y[ccb_pkg::DIM_W-1]}}, item.dest_y};
        x0_a = {{3{item.src_x[ccb_pkg::DIM_W-1]}}, item.src_x};
        y0_a = {{3{item.src_y[ccb_pkg::DIM_W-1]}}, item.src_y};
        sx_a = (item.req_width  != '0) ? {3'b000, item.req_width}  : bw_s;
        sy_a = (item.req_height != '0) ? {3'b000, item.req_height} : bh_s;

        reject_a = (x_a >= sw_s) || (y_a >= sh_s);

        // pull a left or top overhang back onto the screen
        if (x_a < 0)
        begin
            sx_b = sx_a + x_a;
            x0_b = x0_a - x_a;
            x_b  = '0;
        end
        else
        begin
            sx_b = sx_a;
            x0_b = x0_a;
            x_b  = x_a;
        end
        if (y_a < 0)
        begin
            sy_b = sy_a + y_a;
            y0_b = y0_a - y_a;
            y_b  = '0;
        end
        else
        begin
            sy_b = sy_a;
            y0_b = y0_a;
            y_b  = y_a;
        end

        reject_b = (x0_b < 0) || (x0_b >= bw_s) || (y0_b < 0) || (y0_b >= bh_s)
                   || (sx_b <= 0) || (sy_b <= 0);

        // cut at the right and bottom edges of screen, then bitmap
        sx_c = (x_b + sx_b > sw_s) ? sw_s - x_b : sx_b;
        sx_d = (x0_b + sx_c > bw_s) ? bw_s - x0_b : sx_c;
        sy_c = (y_b + sy_b > sh_s) ? sh_s - y_b : sy_b;
        sy_d = (y0_b + sy_c > bh_s) ? bh_s - y0_b : sy_c;

        ok = !reject_a && !reject_b && (sx_d > 0) && (sy_d > 0);

        row_prod = screen_width * y_b[ccb_pkg::DIM_W-1:0];
        src_prod = item.bmp_width * y0_b[ccb_pkg::DIM_W-1:0];

        clip.ok = ok;
        if (ok)
        begin
            clip.width     = sx_d[ccb_pkg::DIM_W-1:0];
            clip.height    = sy_d[ccb_pkg::DIM_W-1:0];
            clip.row_base  = row_prod[ccb_pkg::IDX_W-1:0]
                             + {9'd0, x_b[ccb_pkg::DIM_W-1:0]};
            clip.src_start = src_prod[ccb_pkg::IDX_W-1:0]
                             + {9'd0, x0_b[ccb_pkg::DIM_W-1:0]};
        end
        else
        begin
            clip.width     = '0;
            clip.height    = '0;
            clip.row_base  = '0;
            clip.src_start = '0;
        end
    end

endmodule

// ===== rtl/ccb_walk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccb_walk
// Window state: walks the clipped window in raster order, keys pixels.
// ----------------------------------------------------------------------------
module ccb_walk
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      setup_step,
    input  logic                      pixel_step,
    input  ccb_pkg::clip_t            clip,
    input  logic [ccb_pkg::PIX_W-1:0] key_color,
    input  logic                      key_flag,
    input  logic [ccb_pkg::PIX_W-1:0] pixel,
    input  logic [ccb_pkg::DIM_W-1:0] screen_width,
    output ccb_pkg::pix_res_t         pix_res
);

    logic [ccb_pkg::DIM_W-1:0] win_w_reg, win_w_next, win_h_reg, win_h_next;
    logic [ccb_pkg::DIM_W-1:0] col_reg, col_next, row_reg, row_next;
    logic [ccb_pkg::IDX_W-1:0] row_base_reg, row_base_next;
    logic                      keyed_reg, keyed_next;
    logic [ccb_pkg::PIX_W-1:0] key_reg, key_next;
    logic                      active;
    logic [ccb_pkg::DIM_W:0]   col_inc, row_inc;

    always_comb
    begin
        win_w_next    = win_w_reg;
        win_h_next    = win_h_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_base_next = row_base_reg;
        keyed_next    = keyed_reg;
        key_next      = key_reg;

        active  = (win_w_reg != '0) && (win_h_reg != '0) && (row_reg < win_h_reg);
        col_inc = {1'b0, col_reg} + 12'd1;
        row_inc = {1'b0, row_reg} + 12'd1;

        pix_res = '0;
        if (active)
        begin
            pix_res.dest_index   = row_base_reg + {9'd0, col_reg};
            pix_res.write_enable = !(keyed_reg && (pixel == key_reg));
            pix_res.pixel_out    = pixel;
            pix_res.last         = (col_inc == {1'b0, win_w_reg})
                                   && (row_inc == {1'b0, win_h_reg});
        end

        if (setup_step)
        begin
            win_w_next    = clip.width;
            win_h_next    = clip.height;
            col_next      = '0;
            row_next      = '0;
            row_base_next = clip.row_base;
            keyed_next    = (key_color != '0) || key_flag;
            key_next      = key_color;
        end
        else if (pixel_step && active)
        begin
            if (col_inc >= {1'b0, win_w_reg})
            begin
                col_next      = '0;
                row_next      = row_inc[ccb_pkg::DIM_W-1:0];
                row_base_next = row_base_reg + {9'd0, screen_width};
            end
            else
            begin
                col_next = col_inc[ccb_pkg::DIM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_w_reg    <= '0;
            win_h_reg    <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            row_base_reg <= '0;
            keyed_reg    <= 1'b0;
            key_reg      <= '0;
        end
        else
        begin
            win_w_reg    <= win_w_next;
            win_h_reg    <= win_h_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            row_base_reg <= row_base_next;
            keyed_reg    <= keyed_next;
            key_reg      <= key_next;
        end
    end

endmodule

// ===== rtl/clipped_colorkey_blitter_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_colorkey_blitter_unit
// Rectangle blitter with screen/bitmap clipping and colour-key transparency.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_stall  | req_type .. pixel (setup or pixel request)
//  out     | out_valid / out_stall| accepted .. last (one answer per request)
//  config  | cfg_we               | cfg_index, cfg_data
//
//  One request per clock sustained while out_stall is low; a request's answer
//  shows once it has passed the input register and then the result register.
//  The clip arithmetic and the pixel walk both sit between those registers.
//  Reset clears the window, so pixel requests before a setup answer zero.
//  A stalled result holds in the result register while the input register
//  takes one more request; the input stalls only when both are full and the
//  result is stalled.
// ----------------------------------------------------------------------------
module clipped_colorkey_blitter_unit
(
    input  logic                      clk,
    input  logic                      rst_n,
    // configuration
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [ccb_pkg::DIM_W-1:0] cfg_data,
    // request channel
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      req_type,
    input  logic signed [ccb_pkg::DIM_W-1:0] dest_x,
    input  logic signed [ccb_pkg::DIM_W-1:0] dest_y,
    input  logic [ccb_pkg::DIM_W-1:0] req_width,
    input  logic [ccb_pkg::DIM_W-1:0] req_height,
    input  logic signed [ccb_pkg::DIM_W-1:0] src_x,
    input  logic signed [ccb_pkg::DIM_W-1:0] src_y,
    input  logic [ccb_pkg::DIM_W-1:0] bmp_width,
    input  logic [ccb_pkg::DIM_W-1:0] bmp_height,
    input  logic [ccb_pkg::PIX_W-1:0] key_color,
    input  logic                      key_flag,
    input  logic [ccb_pkg::PIX_W-1:0] pixel,
    // result channel
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      accepted,
    output logic [ccb_pkg::DIM_W-1:0] clip_width,
    output logic [ccb_pkg::DIM_W-1:0] clip_height,
    output logic [ccb_pkg::IDX_W-1:0] src_start,
    output logic [ccb_pkg::IDX_W-1:0] dest_index,
    output logic                      write_enable,
    output logic [ccb_pkg::PIX_W-1:0] pixel_out,
    output logic                      last
);

    // screen geometry registers
    logic [ccb_pkg::DIM_W-1:0] scr_w_reg, scr_w_next, scr_h_reg, scr_h_next;

    // input register and result register
    logic              in_valid_reg, in_valid_next;
    ccb_pkg::item_t    item_reg;
    logic              out_valid_reg, out_valid_next;
    ccb_pkg::result_t  res_reg, res_next;

    logic              out_free, advance, in_take;
    logic              setup_step, pixel_step;
    ccb_pkg::clip_t    clip;
    ccb_pkg::pix_res_t pix_res;

    // the result register frees when empty or when its request is taken
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && out_free;
    assign in_stall = in_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    assign setup_step = advance && (item_reg.req_type == ccb_pkg::REQ_SETUP);
    assign pixel_step = advance && (item_reg.req_type == ccb_pkg::REQ_PIXEL);

    ccb_clip u_clip
    (
        .item          (item_reg),
        .screen_width  (scr_w_reg),
        .screen_height (scr_h_reg),
        .clip          (clip)
    );

    ccb_walk u_walk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .setup_step   (setup_step),
        .pixel_step   (pixel_step),
        .clip         (clip),
        .key_color    (item_reg.key_color),
        .key_flag     (item_reg.key_flag),
        .pixel        (item_reg.pixel),
        .screen_width (scr_w_reg),
        .pix_res      (pix_res)
    );

    always_comb
    begin
        scr_w_next = scr_w_reg;
        scr_h_next = scr_h_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                ccb_pkg::REG_SCREEN_WIDTH:  scr_w_next = cfg_data;
                ccb_pkg::REG_SCREEN_HEIGHT: scr_h_next = cfg_data;
                default:                    scr_w_next = scr_w_reg;
            endcase
        end

        // hold the input register until its request moves on
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        // advance into the result register, or drop a taken result
        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        // a setup answers with the clip; a pixel answers with its write
        res_next = '0;
        if (item_reg.req_type == ccb_pkg::REQ_SETUP)
        begin
            res_next.accepted    = clip.ok;
            res_next.clip_width  = clip.width;
            res_next.clip_height = clip.height;
            res_next.src_start   = clip.src_start;
        end
        else
        begin
            res_next.pix = pix_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg     <= ccb_pkg::SCREEN_WIDTH_RST;
            scr_h_reg     <= ccb_pkg::SCREEN_HEIGHT_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            scr_w_reg     <= scr_w_next;
            scr_h_reg     <= scr_h_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.req_type   <= req_type;
            item_reg.dest_x     <= dest_x;
            item_reg.dest_y     <= dest_y;
            item_reg.req_width  <= req_width;
            item_reg.req_height <= req_height;
            item_reg.src_x      <= src_x;
            item_reg.src_y      <= src_y;
            item_reg.bmp_width  <= bmp_width;
            item_reg.bmp_height <= bmp_height;
            item_reg.key_color  <= key_color;
            item_reg.key_flag   <= key_flag;
            item_reg.pixel      <= pixel;
        end
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = res_reg.accepted;
    assign clip_width   = res_reg.clip_width;
    assign clip_height  = res_reg.clip_height;
    assign src_start    = res_reg.src_start;
    assign dest_index   = res_reg.pix.dest_index;
    assign write_enable = res_reg.pix.write_enable;
    assign pixel_out    = res_reg.pix.pixel_out;
    assign last         = res_reg.pix.last;

    // the input stalls only while its own register is occupied
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
        else $error("input stalled with an empty input register");

    // an accepted setup always opens a nonempty window
    a_accept_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && accepted) |-> (clip_width != '0 && clip_height != '0))
        else $error("accepted setup with empty window");

    // setup answers and pixel answers never mix
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(accepted && (write_enable || last)))
        else $error("result mixes setup and pixel fields");

    // a request that moves on without a follower leaves the input register empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_take) |=> !in_valid_reg)
        else $error("input register kept a request that had moved on");

endmodule
